>>> design/drrt_pkg.sv
// Package with types, codes and constants of the diagnostic request/response tracker.
`timescale 1ns / 1ps

package drrt_pkg;

  // Item kinds carried on the input tuser.
  typedef enum logic [2:0] {
    MODE_START     = 3'd0,
    MODE_TX_DONE   = 3'd1,
    MODE_RESPONSE  = 3'd2,
    MODE_TRANSPORT = 3'd3,
    MODE_POLL      = 3'd4
  } mode_t;

  // Exchange states as they appear on the result.
  typedef enum logic [2:0] {
    XS_IDLE     = 3'd0,
    XS_TX       = 3'd1,
    XS_WAIT     = 3'd2,
    XS_PEND     = 3'd3,
    XS_COMPLETE = 3'd4,
    XS_NEGATIVE = 3'd5,
    XS_ERROR    = 3'd6
  } xstate_t;

  // Event codes carried on the output tuser.
  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_SENT      = 3'd1,
    EV_REPLY     = 3'd2,
    EV_NEGATIVE  = 3'd3,
    EV_PENDING   = 3'd4,
    EV_PROTOCOL  = 3'd5,
    EV_TRANSPORT = 3'd6,
    EV_TIMEOUT   = 3'd7
  } event_t;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_REFUSED = 2'd1;
  localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

  localparam logic [7:0]  NRC_RESPONSE_PENDING    = 8'h78;
  localparam logic [31:0] REPLY_TIMEOUT_DEFAULT   = 32'd50000;
  localparam logic [31:0] PENDING_TIMEOUT_DEFAULT = 32'd5000000;

  localparam int TIME_W    = 64;
  localparam int S_DATA_W  = 104;
  localparam int M_DATA_W  = 32;
  localparam int ADDR_W    = 3;

  // Register select bit of paddr: 0 reply timeout, 1 pending timeout.
  localparam logic REG_REPLY_TIMEOUT   = 1'b0;
  localparam logic REG_PENDING_TIMEOUT = 1'b1;

  // One input transaction after unpacking.
  typedef struct packed {
    logic [2:0]        mode;
    logic [TIME_W-1:0] now_us;
    logic [7:0]        service_code;
    logic              reply_expected;
    logic              decode_ok;
    logic              response_positive;
    logic [7:0]        response_code;
    logic [7:0]        transport_result;
    logic [7:0]        link_error;
  } item_t;

endpackage

>>> design/diagnostic_request_response_tracker_core.sv
// Top level of the diagnostic request/response tracker.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake             Contents
//  s_*       in         s_tvalid / s_tready   one event: start, tx done, response,
//                                             transport error or time poll
//  m_*       out        m_tvalid / m_tready   one result per input event
//  APB       in/out     psel/penable/pwrite   reply and pending timeout registers
//
// Each input transaction is captured in an input register and evaluated, once
// the output register is empty or being drained, by one saturating 64-bit add
// and one 64-bit compare, with the result landing in the output register;
// throughput is one transaction per clock while the output is not stalled.
// A stalled output holds its result while the input register keeps one more
// transaction; s_tready drops only when both are full and m_tready is low.
// Synchronous reset returns the exchange to idle, clears the deadline and the
// kept negative code, and restores both timeouts to their defaults.
module diagnostic_request_response_tracker_core (
  input  logic                           clk,
  input  logic                           rst,
  // Input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // tdata from bit 0 up: now_us[63:0], service_code[71:64], reply_expected[72],
  // decode_ok[73], response_positive[74], response_code[82:75],
  // transport_result[90:83], link_error[98:91], zero fill[103:99]
  input  logic [drrt_pkg::S_DATA_W-1:0] s_tdata,
  // tuser: mode[2:0]
  input  logic [2:0]                     s_tuser,
  // Output stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // tdata from bit 0 up: status[1:0], exchange_state[4:2], busy_res[5],
  // last_negative_code[13:6], event_error[21:14], event_link_error[29:22],
  // zero fill[31:30]
  output logic [drrt_pkg::M_DATA_W-1:0] m_tdata,
  // tuser: event_code[2:0]
  output logic [2:0]                     m_tuser,
  // Configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [drrt_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import drrt_pkg::*;

  // Configuration registers.
  logic [31:0] reply_timeout_us;
  logic [31:0] pending_timeout_us;

  // Exchange state.
  xstate_t           exchange_state;
  xstate_t           exchange_state_next;
  logic [TIME_W-1:0] deadline_time;
  logic [TIME_W-1:0] deadline_time_next;
  logic              expects_reply;
  logic              expects_reply_next;
  logic [7:0]        negative_code;
  logic [7:0]        negative_code_next;

  // Input register.
  logic  in_valid;
  item_t in_item;
  logic  advance;

  // Result of the evaluation stage.
  logic [1:0] status_next;
  event_t     event_next;
  logic [7:0] event_error_next;
  logic [7:0] event_link_error_next;
  logic       busy_next;

  // Output register.
  logic [1:0] out_status;
  event_t     out_event;
  xstate_t    out_state;
  logic       out_busy;
  logic [7:0] out_negative_code;
  logic [7:0] out_event_error;
  logic [7:0] out_event_link_error;

  // Deadline arithmetic.
  logic [31:0]       span;
  logic [TIME_W:0]   deadline_sum;
  logic [TIME_W-1:0] deadline_sat;
  logic              listening;
  logic              deadline_due;

  // ---------------------------------------------------------------------------
  // Configuration port. Writes land at the access cycle; reads are plain muxes.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_timeout_us   <= REPLY_TIMEOUT_DEFAULT;
      pending_timeout_us <= PENDING_TIMEOUT_DEFAULT;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_REPLY_TIMEOUT:   reply_timeout_us   <= pwdata;
        REG_PENDING_TIMEOUT: pending_timeout_us <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_REPLY_TIMEOUT:   prdata = reply_timeout_us;
      REG_PENDING_TIMEOUT: prdata = pending_timeout_us;
      default:             prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Flow control. The input register is evaluated whenever the output register
  // is empty or being drained, so one transaction moves through each cycle.
  // ---------------------------------------------------------------------------
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.mode              <= s_tuser;
      in_item.now_us            <= s_tdata[63:0];
      in_item.service_code      <= s_tdata[71:64];
      in_item.reply_expected    <= s_tdata[72];
      in_item.decode_ok         <= s_tdata[73];
      in_item.response_positive <= s_tdata[74];
      in_item.response_code     <= s_tdata[82:75];
      in_item.transport_result  <= s_tdata[90:83];
      in_item.link_error        <= s_tdata[98:91];
    end
  end

  // ---------------------------------------------------------------------------
  // Deadline arithmetic. One adder serves both timers: a response can only arm
  // the pending timer, a transmit-done only the reply timer. A zero register
  // falls back to its default, and the sum saturates instead of wrapping.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (in_item.mode == MODE_RESPONSE) begin
      span = (pending_timeout_us == '0) ? PENDING_TIMEOUT_DEFAULT : pending_timeout_us;
    end else begin
      span = (reply_timeout_us == '0) ? REPLY_TIMEOUT_DEFAULT : reply_timeout_us;
    end
  end

  assign deadline_sum = {1'b0, in_item.now_us} + {{(TIME_W + 1 - 32){1'b0}}, span};
  assign deadline_sat = deadline_sum[TIME_W] ? {TIME_W{1'b1}} : deadline_sum[TIME_W-1:0];

  assign listening    = (exchange_state == XS_WAIT) || (exchange_state == XS_PEND);
  assign deadline_due = in_item.now_us >= deadline_time;

  // ---------------------------------------------------------------------------
  // Exchange state machine, evaluated for the transaction in the input register.
  // ---------------------------------------------------------------------------
  always_comb begin
    exchange_state_next   = exchange_state;
    deadline_time_next    = deadline_time;
    expects_reply_next    = expects_reply;
    negative_code_next    = negative_code;
    status_next           = STATUS_OK;
    event_next            = EV_NONE;
    event_error_next      = '0;
    event_link_error_next = '0;

    unique case (in_item.mode)
      MODE_START: begin
        if (exchange_state == XS_TX || listening) begin
          status_next = STATUS_REFUSED;
        end else begin
          expects_reply_next  = in_item.reply_expected;
          exchange_state_next = XS_TX;
          deadline_time_next  = '0;
          negative_code_next  = '0;
        end
      end
      MODE_TX_DONE: begin
        if (exchange_state == XS_TX) begin
          if (expects_reply) begin
            exchange_state_next = XS_WAIT;
            deadline_time_next  = deadline_sat;
          end else begin
            exchange_state_next = XS_COMPLETE;
            deadline_time_next  = '0;
            event_next          = EV_SENT;
          end
        end
      end
      MODE_RESPONSE: begin
        if (listening) begin
          if (!in_item.decode_ok) begin
            exchange_state_next = XS_ERROR;
            deadline_time_next  = '0;
            event_next          = EV_PROTOCOL;
            event_error_next    = in_item.transport_result;
          end else if (!in_item.response_positive &&
                       in_item.response_code == NRC_RESPONSE_PENDING) begin
            // The server asked for more time: re-arm with the long timer.
            exchange_state_next = XS_PEND;
            negative_code_next  = in_item.response_code;
            deadline_time_next  = deadline_sat;
            event_next          = EV_PENDING;
          end else if (in_item.response_positive) begin
            deadline_time_next  = '0;
            negative_code_next  = '0;
            exchange_state_next = XS_COMPLETE;
            event_next          = EV_REPLY;
          end else begin
            deadline_time_next  = '0;
            negative_code_next  = in_item.response_code;
            exchange_state_next = XS_NEGATIVE;
            event_next          = EV_NEGATIVE;
          end
        end
      end
      MODE_TRANSPORT: begin
        // A transport failure ends the exchange whatever state it is in.
        exchange_state_next   = XS_ERROR;
        deadline_time_next    = '0;
        event_next            = EV_TRANSPORT;
        event_error_next      = in_item.transport_result;
        event_link_error_next = in_item.link_error;
      end
      MODE_POLL: begin
        if (listening && deadline_due) begin
          exchange_state_next = XS_ERROR;
          deadline_time_next  = '0;
          event_next          = EV_TIMEOUT;
          status_next         = STATUS_TIMEOUT;
        end
      end
      default: ;
    endcase

    busy_next = (exchange_state_next == XS_TX) || (exchange_state_next == XS_WAIT) ||
                (exchange_state_next == XS_PEND);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exchange_state <= XS_IDLE;
      deadline_time  <= '0;
      expects_reply  <= 1'b0;
      negative_code  <= '0;
    end else if (advance) begin
      exchange_state <= exchange_state_next;
      deadline_time  <= deadline_time_next;
      expects_reply  <= expects_reply_next;
      negative_code  <= negative_code_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register. It holds its result until the downstream side takes it.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status           <= status_next;
      out_event            <= event_next;
      out_state            <= exchange_state_next;
      out_busy             <= busy_next;
      out_negative_code    <= negative_code_next;
      out_event_error      <= event_error_next;
      out_event_link_error <= event_link_error_next;
    end
  end

  assign m_tuser = out_event;
  assign m_tdata = {2'b00, out_event_link_error, out_event_error, out_negative_code,
                    out_busy, out_state, out_status};

endmodule

>>> tb/tb.sv
// Self-checking testbench for the diagnostic request/response tracker core.
`timescale 1ns / 1ps

module tb;
  import drrt_pkg::*;

  // Run limits.
  localparam int unsigned CYCLE_LIMIT    = 500000;
  localparam int unsigned HOLDOFF_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS    = 280;
  localparam int unsigned REPORT_LIMIT   = 10;

  // Byte addresses of the two timeout registers.
  localparam logic [ADDR_W-1:0] ADDR_REPLY_TIMEOUT   = {REG_REPLY_TIMEOUT, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_PENDING_TIMEOUT = {REG_PENDING_TIMEOUT, 2'b00};

  localparam logic [63:0] TIME_MAX = '1;

  // One result transaction as seen on the output stream.
  typedef struct packed {
    logic [1:0] status;
    event_t     ev;
    xstate_t    state;
    logic       busy;
    logic [7:0] neg_code;
    logic [7:0] err;
    logic [7:0] sess;
  } tracker_result_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata  = '0;
  logic [2:0]          s_tuser  = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [2:0]          m_tuser;
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [ADDR_W-1:0]   paddr    = '0;
  logic [31:0]         pwdata   = '0;
  logic [31:0]         prdata;
  logic                pready;

  diagnostic_request_response_tracker_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Exchange tracker prediction. These variables mirror the block's own state
  // and its two timeout registers; they are updated once per accepted input
  // transaction, in acceptance order, so stimulus generation can look at them
  // to aim polls just short of, at or just past the armed deadline.
  // ---------------------------------------------------------------------------
  xstate_t     trk_state      = XS_IDLE;
  logic [63:0] trk_deadline   = '0;
  logic [7:0]  trk_service    = '0;
  logic        trk_expects    = 1'b0;
  logic [7:0]  trk_neg_code   = '0;
  logic [7:0]  trk_last_error = '0;
  logic [31:0] cfg_reply_to   = REPLY_TIMEOUT_DEFAULT;
  logic [31:0] cfg_pending_to = PENDING_TIMEOUT_DEFAULT;

  // Results predicted for accepted transactions, oldest first.
  tracker_result_t tracker_outcomes[$];

  int unsigned mismatch_count = 0;
  int unsigned counted_items  = 0;

  // Sender pacing: bursts of random length separated by random gaps.
  int unsigned burst_left = 0;
  bit          gaps_on    = 1'b1;

  // Wall clock used for the time fields of well-formed exchanges.
  logic [63:0] wall_us = 64'd1000;

  // The receiver counts its long hold-off itself; the test only asks for one.
  int unsigned holdoff_requests = 0;
  int unsigned holdoff_seen     = 0;
  int unsigned holdoff_left     = 0;
  logic [1:0]  rx_style         = '0;
  logic [7:0]  rx_left          = '0;

  function automatic logic busy_state(input xstate_t s);
    return (s == XS_TX) || (s == XS_WAIT) || (s == XS_PEND);
  endfunction

  // now + span, where a zero span falls back to the default, clamped at 2^64-1.
  function automatic logic [63:0] deadline_after(input logic [63:0] now,
                                                 input logic [31:0] span,
                                                 input logic [31:0] dflt);
    logic [64:0] sum;
    sum = {1'b0, now} + {33'd0, (span == 32'd0) ? dflt : span};
    return sum[64] ? TIME_MAX : sum[63:0];
  endfunction

  function automatic tracker_result_t track_exchange(input item_t it);
    tracker_result_t r;
    logic            listening;
    r          = '0;
    r.status   = STATUS_OK;
    r.ev       = EV_NONE;
    listening  = (trk_state == XS_WAIT) || (trk_state == XS_PEND);
    case (it.mode)
      MODE_START: begin
        if (busy_state(trk_state)) begin
          r.status = STATUS_REFUSED;
        end else begin
          trk_service    = it.service_code;
          trk_expects    = it.reply_expected;
          trk_state      = XS_TX;
          trk_deadline   = '0;
          trk_last_error = '0;
          trk_neg_code   = '0;
        end
      end
      MODE_TX_DONE: begin
        if (trk_state == XS_TX) begin
          if (trk_expects) begin
            trk_state    = XS_WAIT;
            trk_deadline = deadline_after(it.now_us, cfg_reply_to, REPLY_TIMEOUT_DEFAULT);
          end else begin
            trk_state    = XS_COMPLETE;
            trk_deadline = '0;
            r.ev         = EV_SENT;
          end
        end
      end
      MODE_RESPONSE: begin
        if (listening) begin
          if (!it.decode_ok) begin
            trk_state      = XS_ERROR;
            trk_last_error = it.transport_result;
            trk_deadline   = '0;
            r.ev           = EV_PROTOCOL;
            r.err          = it.transport_result;
          end else if (!it.response_positive
                       && it.response_code == NRC_RESPONSE_PENDING) begin
            // Response pending: stay listening, but on the longer deadline.
            trk_state    = XS_PEND;
            trk_neg_code = it.response_code;
            trk_deadline = deadline_after(it.now_us, cfg_pending_to,
                                          PENDING_TIMEOUT_DEFAULT);
            r.ev         = EV_PENDING;
          end else begin
            trk_deadline   = '0;
            trk_last_error = '0;
            if (it.response_positive) begin
              trk_neg_code = '0;
              trk_state    = XS_COMPLETE;
              r.ev         = EV_REPLY;
            end else begin
              trk_neg_code = it.response_code;
              trk_state    = XS_NEGATIVE;
              r.ev         = EV_NEGATIVE;
            end
          end
        end
      end
      MODE_TRANSPORT: begin
        trk_state      = XS_ERROR;
        trk_last_error = it.transport_result;
        trk_deadline   = '0;
        r.ev           = EV_TRANSPORT;
        r.err          = it.transport_result;
        r.sess         = it.link_error;
      end
      MODE_POLL: begin
        if (listening && it.now_us >= trk_deadline) begin
          trk_state      = XS_ERROR;
          trk_last_error = '0;
          trk_deadline   = '0;
          r.ev           = EV_TIMEOUT;
          r.status       = STATUS_TIMEOUT;
        end
      end
      default: ;
    endcase
    r.state    = trk_state;
    r.busy     = busy_state(trk_state);
    r.neg_code = trk_neg_code;
    return r;
  endfunction

  function automatic string outcome_text(input tracker_result_t r);
    return $sformatf("status=%0d event=%0d state=%0d busy=%0b neg=%02h err=%02h sess=%02h",
                     r.status, r.ev, r.state, r.busy, r.neg_code, r.err, r.sess);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every output transaction is compared field by field with
  // the oldest prediction. A result with nothing predicted is also a failure.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tracker_result_t got;
    tracker_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.status   = m_tdata[1:0];
      got.state    = xstate_t'(m_tdata[4:2]);
      got.busy     = m_tdata[5];
      got.neg_code = m_tdata[13:6];
      got.err      = m_tdata[21:14];
      got.sess     = m_tdata[29:22];
      got.ev       = event_t'(m_tuser);
      if (tracker_outcomes.size() == 0) begin
        if (mismatch_count < REPORT_LIMIT)
          $display("unexpected result at %0t: %s", $realtime, outcome_text(got));
        mismatch_count++;
      end else begin
        want = tracker_outcomes.pop_front();
        if (got.status !== want.status || got.ev !== want.ev || got.state !== want.state
            || got.busy !== want.busy || got.neg_code !== want.neg_code
            || got.err !== want.err || got.sess !== want.sess) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("mismatch at %0t: expected %s, got %s", $realtime,
                     outcome_text(want), outcome_text(got));
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output back-pressure. The receiver switches at random between stall
  // patterns: always ready, mostly ready, mostly stalled, or a periodic
  // on/off pattern. On request it holds off for a long stretch so the
  // block's internal registers fill and s_tready drops.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (holdoff_seen != holdoff_requests) begin
      holdoff_seen <= holdoff_requests;
      holdoff_left <= HOLDOFF_CYCLES;
      m_tready     <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      m_tready     <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_style <= 2'($urandom_range(0, 3));
        rx_left  <= 8'($urandom_range(20, 200));
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_style)
        2'd0:    m_tready <= 1'b1;
        2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
        2'd2:    m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= (rx_left[2:0] < 3'd5);
      endcase
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("diagnostic_request_response_tracker_core verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Offers one input transaction and predicts its result once it is accepted.
  // tvalid stays high between transactions of one burst, and this task lowers
  // it only at the start of a gap.
  task automatic send_item(input item_t it);
    int unsigned     gap;
    tracker_result_t r;
    if (gaps_on && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 12);
    end
    if (burst_left != 0) burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= it.mode;
    s_tdata  <= {5'd0, it.link_error, it.transport_result, it.response_code,
                 it.response_positive, it.decode_ok, it.reply_expected,
                 it.service_code, it.now_us};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = track_exchange(it);
    tracker_outcomes.push_back(r);
    counted_items++;
  endtask

  function automatic item_t make_item(input logic [2:0] mode, input logic [63:0] now);
    item_t it;
    it.mode              = mode;
    it.now_us            = now;
    it.service_code      = 8'($urandom);
    it.reply_expected    = 1'($urandom);
    it.decode_ok         = 1'($urandom);
    it.response_positive = 1'($urandom);
    it.response_code     = 8'($urandom);
    it.transport_result  = 8'($urandom);
    it.link_error        = 8'($urandom);
    return it;
  endfunction

  task automatic send_start(input logic rexp);
    item_t it;
    it                = make_item(MODE_START, wall_us);
    it.reply_expected = rexp;
    send_item(it);
  endtask

  task automatic send_tx_done(input logic [63:0] now);
    send_item(make_item(MODE_TX_DONE, now));
  endtask

  task automatic send_response(input logic [63:0] now, input logic dok, input logic pos,
                               input logic [7:0] code);
    item_t it;
    it                   = make_item(MODE_RESPONSE, now);
    it.decode_ok         = dok;
    it.response_positive = pos;
    it.response_code     = code;
    send_item(it);
  endtask

  task automatic send_poll(input logic [63:0] now);
    send_item(make_item(MODE_POLL, now));
  endtask

  task automatic send_transport(input logic [7:0] tres, input logic [7:0] serr);
    item_t it;
    it                  = make_item(MODE_TRANSPORT, wall_us);
    it.transport_result = tres;
    it.link_error       = serr;
    send_item(it);
  endtask

  // A time strictly before the armed deadline (the deadline itself if it is zero), and one at or just past it.
  function automatic logic [63:0] early_time();
    logic [63:0] span;
    span = (trk_deadline < 64'd1000) ? trk_deadline : 64'd1000;
    return (span == 0) ? trk_deadline : trk_deadline - $urandom_range(1, 32'(span));
  endfunction

  function automatic logic [63:0] late_time();
    logic [63:0] step;
    step = $urandom_range(0, 3);
    return (trk_deadline > TIME_MAX - step) ? TIME_MAX : trk_deadline + step;
  endfunction

  function automatic void advance_wall();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 4)      wall_us = {$urandom, $urandom};
    else if (pick < 8) wall_us = TIME_MAX - $urandom_range(0, 200000);
    else               wall_us = wall_us + $urandom_range(0, 5000);
  endfunction

  // Lowers tvalid and waits until every predicted result has been checked,
  // then lets the two-stage pipeline settle.
  task automatic wait_for_outcomes();
    s_tvalid  <= 1'b0;
    burst_left = 0;
    while (tracker_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Setup cycle, access cycle, then an idle step so back-to-back writes
  // never assign psel twice in one step.
  task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr[2] == REG_REPLY_TIMEOUT) cfg_reply_to = value;
    else                              cfg_pending_to = value;
    @(posedge clk);
  endtask

  task automatic set_timeouts(input logic [31:0] reply_us, input logic [31:0] pending_us);
    wait_for_outcomes();
    write_register(ADDR_REPLY_TIMEOUT, reply_us);
    write_register(ADDR_PENDING_TIMEOUT, pending_us);
  endtask

  // One well-formed exchange with random content: start, transmit done, then
  // a random mix of early and late polls and response-pending replies until a final
  // reply, a timeout or a transport error closes it.
  task automatic run_exchange();
    int unsigned steps;
    int unsigned pick;
    advance_wall();
    send_start($urandom_range(0, 4) != 0);
    if ($urandom_range(0, 9) == 0) send_start(1'($urandom));
    if ($urandom_range(0, 19) == 0) begin
      send_transport(8'($urandom), 8'($urandom));
      return;
    end
    send_tx_done(wall_us);
    steps = 0;
    while ((trk_state == XS_WAIT || trk_state == XS_PEND) && steps < 6) begin
      pick = $urandom_range(0, 99);
      if (pick < 25)      send_poll(early_time());
      else if (pick < 40) send_response(early_time(), 1'b1, 1'b0, NRC_RESPONSE_PENDING);
      else if (pick < 55) send_poll(late_time());
      else if (pick < 88) send_response(early_time(), $urandom_range(0, 9) != 0,
                                        1'($urandom), 8'($urandom));
      else                send_transport(8'($urandom), 8'($urandom));
      steps++;
    end
    if (trk_state == XS_WAIT || trk_state == XS_PEND) send_poll(late_time());
  endtask

  // Short runs of arbitrary transactions, undefined modes included.
  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 3);
    repeat (n) begin
      send_item(make_item(3'($urandom_range(0, 7)),
                          ($urandom_range(0, 1) != 0) ? {$urandom, $urandom} : wall_us));
    end
  endtask

  // Arms a reply deadline at t0, then walks it: not due, pending re-arm,
  // not due, due.
  task automatic exercise_deadlines(input logic [63:0] t0);
    send_start(1'b1);
    send_tx_done(t0);
    send_poll(trk_deadline - 1);
    send_response(trk_deadline - 1, 1'b1, 1'b0, NRC_RESPONSE_PENDING);
    send_poll(trk_deadline - 1);
    send_poll(trk_deadline);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Every item kind and every special case under the reset timeouts.
  task automatic test_directed_cases();
    // Items that do nothing outside their states, and undefined modes.
    send_response(64'd10, 1'b1, 1'b1, 8'h00);
    send_tx_done(64'd20);
    send_item(make_item(3'(MODE_POLL + 1), 64'd30));
    send_item(make_item(3'(MODE_POLL + 3), TIME_MAX));
    // Start, start refused while busy, response ignored while transmitting.
    send_start(1'b1);
    send_start(1'b0);
    send_response(64'd40, 1'b1, 1'b1, 8'h00);
    // P2 armed, re-armed to P2* by response pending, then timed out exactly.
    send_tx_done(64'd1000);
    send_response(64'd2000, 1'b1, 1'b0, NRC_RESPONSE_PENDING);
    send_poll(trk_deadline - 1);
    send_poll(trk_deadline);
    // Suppressed reply completes on transmit done.
    send_start(1'b0);
    send_tx_done(64'd3000);
    // Deadline saturates at the top of the time range.
    send_start(1'b1);
    send_tx_done(TIME_MAX - 10);
    send_poll(TIME_MAX - 1);
    send_poll(TIME_MAX);
    // Decode failure is a protocol error carrying the transport code.
    send_start(1'b1);
    send_tx_done(64'd0);
    send_response(64'd5, 1'b0, 1'b1, 8'h00);
    // Negative reply keeps its code; the next start clears it.
    send_start(1'b1);
    send_tx_done(64'd100);
    send_response(64'd200, 1'b1, 1'b0, 8'h31);
    send_start(1'b1);
    send_tx_done(64'd300);
    send_response(64'd400, 1'b1, 1'b1, 8'hFF);
    // Transport error is taken in any state.
    send_transport(8'hFF, 8'hFF);
  endtask

  // Timeout registers at their extremes; zero selects the built-in defaults.
  task automatic test_timeout_extremes();
    set_timeouts(32'd1, 32'd1);
    exercise_deadlines(64'd0);
    exercise_deadlines(TIME_MAX - 3);
    set_timeouts(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    exercise_deadlines(64'd0);
    exercise_deadlines(TIME_MAX - 3);
    set_timeouts(32'd0, 32'd0);
    exercise_deadlines(64'd7);
  endtask

  // Bulk random exchanges over several timeout settings.
  task automatic test_random_traffic();
    int unsigned phase_start;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       set_timeouts(REPLY_TIMEOUT_DEFAULT, PENDING_TIMEOUT_DEFAULT);
        1:       set_timeouts($urandom_range(1, 5000), $urandom_range(1, 5000));
        2:       set_timeouts(32'd1, 32'd1);
        3:       set_timeouts(32'hFFFF_FFFF, $urandom);
        4:       set_timeouts(32'd0, $urandom);
        default: set_timeouts($urandom, 32'd0);
      endcase
      phase_start = counted_items;
      while (counted_items - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 5) == 0) send_noise();
        else                           run_exchange();
      end
    end
  endtask

  // Long receiver hold-off while the sender keeps offering without gaps.
  task automatic test_output_backpressure();
    wait_for_outcomes();
    gaps_on = 1'b0;
    holdoff_requests <= holdoff_requests + 1;
    repeat (12) run_exchange();
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_timeout_extremes();
    test_random_traffic();
    test_output_backpressure();
    wait_for_outcomes();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && tracker_outcomes.size() == 0) begin
      $display("diagnostic_request_response_tracker_core verification clean");
    end else begin
      $display("diagnostic_request_response_tracker_core verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
design/drrt_pkg.sv
design/diagnostic_request_response_tracker_core.sv
tb/tb.sv
